// ----- src/drst_pkg.sv -----
// Shared constants and opcodes for the dense rank sorted table unit.
package drst_pkg;

  localparam int OPCODE_W         = 2;
  localparam int SCORE_IN_W       = 32;
  localparam int RANK_W           = 11;
  localparam int DEF_MAX_ENTRIES  = 1024;
  localparam int DEF_SCORE_BITS   = 32;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OPC_CLEAR = 2'd0;
  localparam opcode_t OPC_LOAD  = 2'd1;
  localparam opcode_t OPC_QUERY = 2'd2;
  localparam opcode_t OPC_NONE  = 2'd3;

endpackage

// ----- src/drst_if.sv -----
// Valid/ready channel interfaces for request and result traffic.
interface drst_in_if;
  import drst_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [SCORE_IN_W-1:0] score_value;

  modport source(output valid, output opcode, output score_value, input ready);
  modport sink(input valid, input opcode, input score_value, output ready);
endinterface

interface drst_out_if;
  import drst_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic              overflow;

  modport source(output valid, output rank, output overflow, input ready);
  modport sink(input valid, input rank, input overflow, output ready);
endinterface

// ----- src/dense_rank_sorted_table_unit.sv -----
// Top level of the dense rank sorted table unit.
// Keeps distinct reference scores in load order (descending by convention) and answers
// the dense rank of ascending query scores with a sticky overflow flag. Requests enter a
// two-entry queue, so the input accepts while a result waits, until the queue fills.
// Clear and load requests act in the back end's idle state; opcode 3 is accepted and
// dropped. A query reads the table, then walks the search pointer through the registered
// read port of the table memory; since the pointer only moves forward until the next
// load or clear, the walk over a run of queries totals at most the table size. A query
// leaves the queue only once the result register is empty.
module dense_rank_sorted_table_unit #(
  parameter int MAX_ENTRIES = drst_pkg::DEF_MAX_ENTRIES,
  parameter int SCORE_BITS  = drst_pkg::DEF_SCORE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  drst_in_if.sink    in_if,
  drst_out_if.source out_if
);
  import drst_pkg::*;

  localparam int QDW = OPCODE_W + SCORE_BITS;

  logic                  push_valid;
  logic                  push_ready;
  opcode_t               push_op;
  logic [SCORE_BITS-1:0] push_value;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [QDW-1:0]        pop_data;
  opcode_t               pop_op;
  logic [SCORE_BITS-1:0] pop_value;

  assign pop_op    = pop_data[QDW-1 -: OPCODE_W];
  assign pop_value = pop_data[SCORE_BITS-1:0];

  drst_front #(
    .SCORE_BITS (SCORE_BITS)
  ) u_front (
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_value (push_value)
  );

  drst_queue #(
    .DW (QDW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_op, push_value}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  drst_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCORE_BITS  (SCORE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .pop_value (pop_value),
    .out_if    (out_if)
  );

  a_unused_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && (in_if.opcode == OPC_NONE)) |-> !push_valid)
    else $error("unused opcode entered the queue");

  a_query_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && (pop_op == OPC_QUERY)) |-> !out_if.valid)
    else $error("query started with result register occupied");

  a_query_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && (pop_op == OPC_QUERY)) |=> !out_if.valid ##1 !out_if.valid)
    else $error("query result appeared before table read");

endmodule

// ----- src/drst_front.sv -----
// Front end: accepts requests, drops unused opcodes, trims the score to table width.
module drst_front #(
  parameter int SCORE_BITS = drst_pkg::DEF_SCORE_BITS
) (
  drst_in_if.sink                 in_if,
  output logic                    push_valid,
  input  logic                    push_ready,
  output drst_pkg::opcode_t       push_op,
  output logic [SCORE_BITS-1:0]   push_value
);
  import drst_pkg::*;

  localparam int KEEP_W = (SCORE_BITS < SCORE_IN_W) ? SCORE_BITS : SCORE_IN_W;

  assign in_if.ready = push_ready;
  assign push_valid  = in_if.valid && (in_if.opcode != OPC_NONE);
  assign push_op     = in_if.opcode;
  assign push_value  = SCORE_BITS'(in_if.score_value[KEEP_W-1:0]);

endmodule

// ----- src/drst_queue.sv -----
// Two-entry request queue between front and back end.
module drst_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/drst_back.sv -----
// Back end: score table memory, load/clear handling and the pointer walk for queries.
module drst_back #(
  parameter int MAX_ENTRIES = drst_pkg::DEF_MAX_ENTRIES,
  parameter int SCORE_BITS  = drst_pkg::DEF_SCORE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  drst_pkg::opcode_t     pop_op,
  input  logic [SCORE_BITS-1:0] pop_value,
  drst_out_if.source            out_if
);
  import drst_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = (CNT_W + 1 > RANK_W) ? CNT_W + 1 : RANK_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [SCORE_BITS-1:0] mem [MAX_ENTRIES];
  logic [SCORE_BITS-1:0] rd_data_r;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [SCORE_BITS-1:0] last_r, last_nxt;
  logic [SCORE_BITS-1:0] qval_r, qval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]     out_rank_r, out_rank_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  mem_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      rd_diff;
  logic [SUM_W-1:0]      rank_sum;
  logic                  dup;

  assign wr_addr  = count_r[ADDR_W-1:0];
  assign rd_diff  = count_r - CNT_W'(1) - ptr_nxt;
  assign rd_addr  = rd_diff[ADDR_W-1:0];
  assign rank_sum = SUM_W'(count_r) - SUM_W'(ptr_r) + SUM_W'(1);
  assign dup      = (count_r != '0) && (last_r == pop_value);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    qval_nxt      = qval_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_rank_nxt  = out_rank_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    pop_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        // a query needs the result register free when its walk ends
        pop_ready = (pop_op != OPC_QUERY) || !out_valid_r;
        if (pop_valid && pop_ready) begin
          case (pop_op)
            OPC_CLEAR: begin
              count_nxt = '0;
              ptr_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
            OPC_LOAD: begin
              if (!dup) begin
                if (count_r == CNT_W'(MAX_ENTRIES)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  last_nxt  = pop_value;
                  count_nxt = count_r + CNT_W'(1);
                  ptr_nxt   = '0;
                end
              end
            end
            OPC_QUERY: begin
              qval_nxt  = pop_value;
              state_nxt = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // read for ptr_nxt is issued every cycle, so the walk compares the entry at ptr_r each step
        if ((ptr_r < count_r) && (rd_data_r <= qval_r)) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = rank_sum[RANK_W-1:0];
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= pop_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    qval_r     <= qval_nxt;
    out_rank_r <= out_rank_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.rank     = out_rank_r;
  assign out_if.overflow = out_ovf_r;

endmodule

// ----- sim/dense_rank_sorted_table_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dense rank sorted table unit: directed table, table fill, then random.
module dense_rank_sorted_table_unit_tb;
  import drst_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
  localparam int RANDOM_ITEMS = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              overflow;
  } rank_result_t;

  typedef struct packed {
    opcode_t           op;
    logic [31:0]       score;
    logic              typed;
    logic [RANK_W-1:0] rank;
    logic              overflow;
  } directed_row_t;

  logic clk;
  logic rst_n;

  drst_in_if  req_ch ();
  drst_out_if rank_ch ();

  dense_rank_sorted_table_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rank_ch)
  );

  logic [31:0]   score_tbl [TABLE_DEPTH];
  int            score_cnt;
  int            walk_ptr;
  logic          sticky_ovf;
  rank_result_t  pending_ranks [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  int            mismatch_count;
  int            sent_count;
  int            cycle_count;
  bit            src_burst;
  bit            snk_burst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Dense rank of one request; returns 1 when the request yields a result.
  function automatic bit dense_rank_step(input opcode_t op, input logic [31:0] score,
                                         output rank_result_t res);
    res = '0;
    case (op)
      OPC_CLEAR: begin
        score_cnt  = 0;
        walk_ptr   = 0;
        sticky_ovf = 1'b0;
      end
      OPC_LOAD: begin
        if (!(score_cnt > 0 && score_tbl[score_cnt-1] == score)) begin
          if (score_cnt >= TABLE_DEPTH) begin
            sticky_ovf = 1'b1;
          end else begin
            score_tbl[score_cnt] = score;
            score_cnt++;
            walk_ptr = 0;
          end
        end
      end
      OPC_QUERY: begin
        while (walk_ptr < score_cnt && score_tbl[score_cnt-1-walk_ptr] <= score)
          walk_ptr++;
        res.rank     = RANK_W'(score_cnt - walk_ptr + 1);
        res.overflow = sticky_ovf;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic push_request(input opcode_t op, input logic [31:0] score, input logic typed,
                              input logic [RANK_W-1:0] t_rank, input logic t_ovf);
    int           gap;
    rank_result_t res;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.score_value <= score;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (dense_rank_step(op, score, res)) begin
      if (typed) begin
        res.rank     = t_rank;
        res.overflow = t_ovf;
      end
      pending_ranks = {pending_ranks, res};
    end
    if (op != OPC_NONE)
      sent_count++;
  endtask

  task automatic issue(input opcode_t op, input logic [31:0] score);
    push_request(op, score, 1'b0, '0, 1'b0);
  endtask

  // Fills the table to capacity, then pushes loads past the end and queries it, then clears it and queries again.
  task automatic fill_table();
    longint v;
    longint q;
    logic [31:0] last;
    issue(OPC_CLEAR, $urandom);
    v = 64'hFFFF_FFFF - $urandom_range(0, 32'h0FFF_FFFF);
    last = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      issue(OPC_LOAD, v[31:0]);
      if ($urandom_range(0, 31) == 0)
        issue(OPC_LOAD, v[31:0]);
      last = v[31:0];
      v -= $urandom_range(1, 32'h001F_FFFF);
    end
    issue(OPC_LOAD, last);
    issue(OPC_LOAD, v[31:0]);
    issue(OPC_LOAD, $urandom);
    issue(OPC_QUERY, 32'd0);
    q = v;
    for (int i = 0; i < 16; i++) begin
      q += $urandom_range(0, 32'h0FFF_FFFF);
      if (q > 64'hFFFF_FFFF)
        q = 64'hFFFF_FFFF;
      issue(OPC_QUERY, q[31:0]);
    end
    issue(OPC_CLEAR, $urandom);
    issue(OPC_QUERY, $urandom);
  endtask

  // Descending loads with random content followed by mostly ascending queries, with the odd random load.
  task automatic sorted_phase();
    longint top;
    longint v;
    longint lo;
    longint hi;
    longint q;
    longint qb;
    longint incr;
    int     n;
    int     m;
    int     step_max;
    if ($urandom_range(0, 9) < 8)
      issue(OPC_CLEAR, $urandom);
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 16;
      2: step_max = 32'h0001_0000;
      default: step_max = 32'h0100_0000;
    endcase
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
    top = $urandom;
    v = top;
    for (int i = 0; i < n; i++) begin
      issue(OPC_LOAD, v[31:0]);
      if ($urandom_range(0, 7) == 0)
        issue(OPC_LOAD, v[31:0]);
      v -= $urandom_range(1, step_max);
      if (v < 0)
        v = 0;
    end
    lo = v - step_max;
    if (lo < 0)
      lo = 0;
    hi = top + step_max;
    if (hi > 64'hFFFF_FFFF)
      hi = 64'hFFFF_FFFF;
    m = $urandom_range(1, 12);
    q = lo;
    for (int i = 0; i < m; i++) begin
      incr = (hi - lo) / m + 1;
      if (incr > 64'hFFFF_FFFF)
        incr = 64'hFFFF_FFFF;
      q += $urandom_range(0, incr[31:0]);
      if (q > 64'hFFFF_FFFF)
        q = 64'hFFFF_FFFF;
      if ($urandom_range(0, 9) == 0) begin
        qb = q - $urandom_range(0, step_max);
        if (qb < 0)
          qb = 0;
        issue(OPC_QUERY, qb[31:0]);
      end else begin
        issue(OPC_QUERY, q[31:0]);
      end
      if ($urandom_range(0, 15) == 0)
        issue(OPC_LOAD, $urandom);
    end
  endtask

  // Unordered loads and queries, or any opcode at all when any_op is set.
  task automatic scrambled_phase(input bit any_op);
    int          k;
    opcode_t     op;
    logic [31:0] score;
    k = $urandom_range(4, 16);
    for (int i = 0; i < k; i++) begin
      if (any_op)
        op = opcode_t'($urandom_range(0, 3));
      else
        op = $urandom_range(0, 1) ? OPC_LOAD : OPC_QUERY;
      score = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      issue(op, score);
    end
  endtask

  initial begin : result_sink
    int stall;
    rank_result_t want;
    rank_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = snk_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rank_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rank_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rank_ch.valid && rank_ch.ready));
      if (pending_ranks.size() == 0) begin
        $display("%0t: result with none pending: rank %0d overflow %0b",
                 $time, rank_ch.rank, rank_ch.overflow);
        mismatch_count++;
      end else begin
        want = pending_ranks.pop_front();
        if (rank_ch.rank !== want.rank) begin
          $display("%0t: rank mismatch: expected %0d actual %0d", $time, want.rank, rank_ch.rank);
          mismatch_count++;
        end
        if (rank_ch.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %0b actual %0b",
                   $time, want.overflow, rank_ch.overflow);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int random_goal;
    int pick;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= OPC_NONE;
    req_ch.score_value <= '0;
    score_cnt      = 0;
    walk_ptr       = 0;
    sticky_ovf     = 1'b0;
    mismatch_count = 0;
    sent_count     = 0;
    cycle_count    = 0;
    src_burst      = 1'b0;
    snk_burst      = 1'b0;
    directed_rows = '{
      '{OPC_QUERY, 32'h0000_0000, 1'b1, 11'd1, 1'b0},
      '{OPC_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b0},
      '{OPC_NONE,  32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OPC_LOAD,  32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OPC_LOAD,  32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OPC_LOAD,  32'd1000,      1'b0, 11'd0, 1'b0},
      '{OPC_LOAD,  32'd0,         1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd0,         1'b1, 11'd3, 1'b0},
      '{OPC_QUERY, 32'd500,       1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd1000,      1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd5,         1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b0},
      '{OPC_LOAD,  32'd0,         1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd0,         1'b0, 11'd0, 1'b0},
      '{OPC_LOAD,  32'd2000,      1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd1500,      1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd3000,      1'b0, 11'd0, 1'b0},
      '{OPC_CLEAR, 32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd0,         1'b1, 11'd1, 1'b0},
      '{OPC_LOAD,  32'd0,         1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'd0,         1'b0, 11'd0, 1'b0},
      '{OPC_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b0},
      '{OPC_CLEAR, 32'd0,         1'b0, 11'd0, 1'b0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      push_request(directed_rows[i].op, directed_rows[i].score, directed_rows[i].typed,
                   directed_rows[i].rank, directed_rows[i].overflow);
    fill_table();
    random_goal = sent_count + RANDOM_ITEMS;
    while (sent_count < random_goal) begin
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        sorted_phase();
      else if (pick < 85)
        scrambled_phase(1'b0);
      else
        scrambled_phase(1'b1);
    end
    req_ch.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
